// ===== rtl/ght_pkg.sv =====
// Shared types and constants for the glow plug heat timer.
// Holds the request/result item structs, the register index codes and fixed-point constants.
// No dependencies.
`default_nettype none

package ght_pkg;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_LOOP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		CFG_MIN_GLOW_TEMP    = 2'd0,
		CFG_COLD_ENGINE_TEMP = 2'd1,
		CFG_RPM_RUNNING      = 2'd2,
		CFG_AFTER_START_MULT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		func_t             func;
		logic signed [11:0] temp_tenths;
		logic [12:0]       engine_rpm;
		logic              second_tick;
	} req_t;

	typedef struct packed {
		logic plug_on;
		logic lamp_on;
		logic heating;
	} rsp_t;

	// Decoded item: heat time and compare flags already worked out
	typedef struct packed {
		func_t      func;
		logic [6:0] heat;
		logic       ge50;
		logic       above_cold;
		logic       running;
		logic       tick;
	} item_t;

	localparam int CFG_DATA_W = 13;

	localparam logic signed [11:0] MIN_GLOW_RST    = 12'sd290;
	localparam logic signed [11:0] COLD_ENGINE_RST = 12'sd500;
	localparam logic [12:0]        RPM_RUNNING_RST = 13'd500;
	localparam logic [3:0]         MULT_RST        = 4'd2;

	// Heat time base: (600 - temp) / 35
	localparam logic signed [12:0] HEAT_BASE_TEMP = 13'sd600;
	// ceil(2^17 / 35), exact for 12-bit dividends
	localparam logic [11:0]        RECIP35        = 12'd3745;
	localparam int                 RECIP35_SHIFT  = 17;
	// ceil(2^7 / 3), exact for 7-bit dividends
	localparam logic [12:0]        RECIP3         = 13'd43;
	localparam int                 RECIP3_SHIFT   = 7;

	localparam logic signed [11:0] LAMP_SHORT_TEMP = 12'sd50;
	localparam logic [8:0]         HEAT_MAX        = 9'd511;
	localparam logic [4:0]         LAMP_MAX        = 5'd31;

endpackage

`default_nettype wire

// ===== rtl/ght_heat_calc.sv =====
// Front-end decode of one request item: heat time from temperature and the compare flags.
// Depends on ght_pkg. Purely combinational; result is registered by the top level.
`default_nettype none

module ght_heat_calc
	import ght_pkg::*;
(
	input  req_t               req,
	input  logic signed [11:0] min_glow_temp,
	input  logic signed [11:0] cold_engine_temp,
	input  logic [12:0]        rpm_running,
	output item_t              item
);

	logic signed [12:0] diff;
	logic [23:0]        prod;
	logic               no_heat;

	always_comb begin
		diff    = HEAT_BASE_TEMP - 13'(req.temp_tenths);
		no_heat = (req.temp_tenths >= min_glow_temp) || (diff <= 13'sd0);
		// divide by 35 through the reciprocal; diff is below 4096 when positive
		prod    = {12'd0, diff[11:0]} * {12'd0, RECIP35};

		item.func       = req.func;
		item.heat       = no_heat ? 7'd0 : prod[RECIP35_SHIFT +: 7];
		item.ge50       = req.temp_tenths >= LAMP_SHORT_TEMP;
		item.above_cold = req.temp_tenths > cold_engine_temp;
		item.running    = req.engine_rpm > rpm_running;
		item.tick       = req.second_tick;
	end

endmodule

`default_nettype wire

// ===== rtl/ght_timer.sv =====
// Timer state of the glow plug controller: heat and lamp countdowns, warm latch, drive levels.
// Depends on ght_pkg. Updates state and forms the result for one decoded item per advance.
`default_nettype none

module ght_timer
	import ght_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  item_t      item,
	input  logic [3:0] mult,
	output rsp_t       rsp
);

	logic [8:0]  heat_q, heat_n;
	logic [4:0]  lamp_q, lamp_n;
	logic        warm_q, warm_n;
	logic        plug_q, plug_n;
	logic        lampon_q, lampon_n;
	logic        hdone_q, hdone_n;
	logic        ldone_q, ldone_n;
	logic [12:0] div3_prod;
	logic [5:0]  lamp_raw;
	logic [10:0] mult_prod;
	logic [8:0]  heat_sat;

	always_comb begin
		div3_prod = {6'd0, item.heat} * RECIP3;
		lamp_raw  = item.ge50 ? {2'd0, item.heat[6:3]} : div3_prod[RECIP3_SHIFT +: 6];
		mult_prod = {4'd0, item.heat} * {7'd0, mult};
		heat_sat  = (mult_prod > {2'd0, HEAT_MAX}) ? HEAT_MAX : mult_prod[8:0];

		heat_n   = heat_q;
		lamp_n   = lamp_q;
		warm_n   = warm_q;
		plug_n   = plug_q;
		lampon_n = lampon_q;
		hdone_n  = hdone_q;
		ldone_n  = ldone_q;

		case (item.func)
			FUNC_START: begin
				heat_n  = {2'd0, item.heat};
				hdone_n = 1'b0;
				if (item.heat != 7'd0) begin
					plug_n   = 1'b1;
					lampon_n = 1'b1;
					lamp_n   = (lamp_raw > {1'b0, LAMP_MAX}) ? LAMP_MAX : lamp_raw[4:0];
					ldone_n  = 1'b0;
				end
			end
			FUNC_LOOP: begin
				if (item.above_cold) warm_n = 1'b1;
				// after-start heating on a running cold engine
				if (!warm_n && item.running) begin
					heat_n  = {2'd0, item.heat};
					hdone_n = 1'b0;
					if (item.heat != 7'd0) begin
						heat_n = heat_sat;
						plug_n = 1'b1;
						warm_n = 1'b1;
					end
				end
				if (item.tick && !hdone_n) begin
					if (heat_n == 9'd0) begin
						plug_n  = 1'b0;
						hdone_n = 1'b1;
					end else begin
						heat_n = heat_n - 9'd1;
					end
					if (!ldone_n) begin
						if (lamp_n == 5'd0) begin
							lampon_n = 1'b0;
							ldone_n  = 1'b1;
						end else begin
							lamp_n = lamp_n - 5'd1;
						end
					end
				end
			end
			default: ;
		endcase

		rsp.plug_on = plug_n;
		rsp.lamp_on = lampon_n;
		rsp.heating = !hdone_n && (heat_n != 9'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_q   <= '0;
			lamp_q   <= '0;
			warm_q   <= 1'b0;
			plug_q   <= 1'b0;
			lampon_q <= 1'b0;
			hdone_q  <= 1'b0;
			ldone_q  <= 1'b0;
		end else if (advance) begin
			heat_q   <= heat_n;
			lamp_q   <= lamp_n;
			warm_q   <= warm_n;
			plug_q   <= plug_n;
			lampon_q <= lampon_n;
			hdone_q  <= hdone_n;
			ldone_q  <= ldone_n;
		end
	end

	// heat time left always means the plug is driven
	a_heat_plug: assert property (@(posedge clk) disable iff (!arst_n)
		(!hdone_q && heat_q != 9'd0) |-> plug_q)
		else $error("heat time pending with plug off");

	a_hdone_plug: assert property (@(posedge clk) disable iff (!arst_n)
		hdone_q |-> !plug_q)
		else $error("plug on after heat timer ran out");

	a_ldone_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		ldone_q |-> !lampon_q)
		else $error("lamp on after lamp timer ran out");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(heat_q) && $stable(lamp_q) && $stable(warm_q)))
		else $error("timer state moved without an item");

endmodule

`default_nettype wire

// ===== rtl/glow_plug_heat_timer.sv =====
// Top level of the glow plug heat timer: config registers, input stage and result register.
// Depends on ght_pkg, ght_heat_calc and ght_timer.
//
//   port group                  dir   payload
//   req_valid/req_ready/req     in    req_t: func, temp_tenths, engine_rpm, second_tick
//   rsp_valid/rsp_ready/rsp     out   rsp_t: plug_on, lamp_on, heating
//   cfg_valid/cfg_ready         in    cfg_index (cfg_idx_t), cfg_data (13 bits)
//
// One item per cycle sustained while results are taken; a taken item passes the input stage
// register (heat-time divide) and then the result register (timer update).
// Reset clears the timers, latch and drive levels and loads the register defaults.
// A stalled result holds; the input stage still takes one more item behind it.
// Config writes are always ready.
`default_nettype none

module glow_plug_heat_timer
	import ght_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [11:0] min_glow_q;
	logic signed [11:0] cold_engine_q;
	logic [12:0]        rpm_running_q;
	logic [3:0]         mult_q;

	item_t item_d;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	rsp_t  rsp_d;
	rsp_t  rsp_q;
	logic  rsp_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_glow_q    <= MIN_GLOW_RST;
			cold_engine_q <= COLD_ENGINE_RST;
			rpm_running_q <= RPM_RUNNING_RST;
			mult_q        <= MULT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_GLOW_TEMP:    min_glow_q    <= cfg_data[11:0];
				CFG_COLD_ENGINE_TEMP: cold_engine_q <= cfg_data[11:0];
				CFG_RPM_RUNNING:      rpm_running_q <= cfg_data[12:0];
				CFG_AFTER_START_MULT: mult_q        <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ght_heat_calc u_calc (
		.req              (req),
		.min_glow_temp    (min_glow_q),
		.cold_engine_temp (cold_engine_q),
		.rpm_running      (rpm_running_q),
		.item             (item_d)
	);

	// move the staged item into the timer when the result slot is free
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= item_d;
		end
	end

	ght_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.mult    (mult_q),
		.rsp     (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_advance_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("item advanced without a result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp_ready) |=> valid_s1)
		else $error("staged item dropped while result stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("input stage empty but not ready");

endmodule

`default_nettype wire
